[src/bra_pkg.sv]
// Shared types, widths and operation codes for the bitmap run allocator.
`default_nettype none

package bra_pkg;

    localparam int MAP_BITS_DEF = 4096;

    localparam int OP_W    = 3;
    localparam int IDX_W   = 12;
    localparam int LEN_W   = 13;
    localparam int USED_W  = 10;

    localparam logic [USED_W-1:0] USED_RESET = 10'd512;

    localparam logic [OP_W-1:0] OP_TEST      = 3'd0;
    localparam logic [OP_W-1:0] OP_SET       = 3'd1;
    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd2;
    localparam logic [OP_W-1:0] OP_FIND      = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR_MAP = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [IDX_W-1:0] bit_index;
        logic [LEN_W-1:0] run_length;
    } req_t;

    typedef struct packed {
        logic             bit_value;
        logic             found;
        logic [IDX_W-1:0] start_index;
    } rsp_t;

    typedef logic [USED_W-1:0] used_t;

    // Controller to scanner
    typedef struct packed {
        logic clr;
        logic step;
    } scan_ctl_t;

    // Scanner to controller
    typedef struct packed {
        logic       hit;
        logic [2:0] pos;
    } scan_res_t;

endpackage

`default_nettype wire

[src/bra_chan_if.sv]
// Valid/ready channel carrying one payload word.
`default_nettype none

interface bra_chan_if #(
    parameter type data_t = logic
);
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/bra_map_ram.sv]
// Map byte memory: one write port, one read port, registered read data.
`default_nettype none

module bra_map_ram #(
    parameter int DEPTH  = 512,
    parameter int ADDR_W = 9
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [7:0]        wr_data,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [7:0]        rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[src/bra_run_scan.sv]
// Free-run counter: takes one map byte per step, eight bits LSB first.
`default_nettype none

module bra_run_scan
    import bra_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire scan_ctl_t        ctl,
    input  wire logic [7:0]       map_byte,
    input  wire logic [LEN_W-1:0] run_length,
    output scan_res_t             res
);

    logic [LEN_W-1:0] run_reg;
    logic [LEN_W-1:0] run_next;
    logic [LEN_W-1:0] run_walk;
    scan_res_t        res_c;

    // Run never exceeds run_length - 1 before a hit, so the increment fits.
    always_comb
    begin
        run_walk = run_reg;
        res_c    = '0;
        for (int k = 0; k < 8; k++)
        begin
            if (!res_c.hit)
            begin
                if (map_byte[k])
                begin
                    run_walk = '0;
                end
                else
                begin
                    run_walk = LEN_W'(run_walk + 1'b1);
                end
                if (run_walk == run_length)
                begin
                    res_c.hit = 1'b1;
                    res_c.pos = 3'(k);
                end
            end
        end
    end

    always_comb
    begin
        run_next = run_reg;
        if (ctl.clr)
        begin
            run_next = '0;
        end
        else if (ctl.step)
        begin
            run_next = run_walk;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
        end
    end

    assign res = res_c;

endmodule

`default_nettype wire

[src/bitmap_run_allocator_unit.sv]
// Top level of the bitmap run allocator: controller, map memory and run scanner.
//
//  channel | dir | payload                                  | word moves when
//  --------+-----+------------------------------------------+------------------------
//  req     | in  | operation, bit_index, run_length (req_t) | req.valid & req.ready
//  rsp     | out | bit_value, found, start_index (rsp_t)    | rsp.valid & rsp.ready
//  cfg     | in  | used_bytes (used_t)                      | cfg.valid & cfg.ready
//
// Test, set and clear bit: read the map byte, then modify/write it and load the
// result register; an index past the map or an unknown code skips both steps.
// Find: the map memory's single read port feeds one byte per cycle to the run
// scanner. Clear map: one byte written per cycle.
// After reset a clearing pass zeroes the map; req is not taken meanwhile, cfg
// writes are. One request is worked on at a time; the next is taken while a
// finished word still waits in the rsp register.
`default_nettype none

module bitmap_run_allocator_unit
    import bra_pkg::*;
#(
    parameter int MAP_BITS = MAP_BITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bra_chan_if.sink   req,
    bra_chan_if.source rsp,
    bra_chan_if.sink   cfg
);

    localparam int MAP_BYTES = (MAP_BITS + 7) / 8;
    localparam int ADDR_W    = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int CNT_W     = $clog2(MAP_BYTES + 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAP_BYTES - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_BIT,
        S_FIND,
        S_HOLD
    } state_t;

    state_t            state_reg,     state_next;
    logic [ADDR_W-1:0] clr_addr_reg,  clr_addr_next;
    logic              clr_op_reg,    clr_op_next;
    logic [OP_W-1:0]   op_reg,        op_next;
    logic [IDX_W-1:0]  bidx_reg,      bidx_next;
    logic [LEN_W-1:0]  len_reg,       len_next;
    logic [CNT_W-1:0]  scan_rd_reg,   scan_rd_next;
    logic [ADDR_W-1:0] proc_addr_reg, proc_addr_next;
    logic              rd_pend_reg,   rd_pend_next;
    rsp_t              res_reg,       res_next;
    rsp_t              out_reg,       out_next;
    logic              out_valid_reg, out_valid_next;
    used_t             used_reg;

    // memory port controls
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [7:0]        mem_wd;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_ra;
    logic [7:0]        mem_rd;

    scan_ctl_t         scan_ctl;
    scan_res_t         scan_res;

    logic              req_fire;
    logic              idx_inside;
    logic [CNT_W-1:0]  lim_bytes;
    logic              len_too_big;
    logic [7:0]        bit_mask;
    logic [31:0]       start_full;

    bra_map_ram #(
        .DEPTH  (MAP_BYTES),
        .ADDR_W (ADDR_W)
    ) u_map_ram (
        .clk     (clk),
        .we      (mem_we),
        .wr_addr (mem_wa),
        .wr_data (mem_wd),
        .re      (mem_re),
        .rd_addr (mem_ra),
        .rd_data (mem_rd)
    );

    bra_run_scan u_run_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (scan_ctl),
        .map_byte   (mem_rd),
        .run_length (len_reg),
        .res        (scan_res)
    );

    // config: always ready; it is to be written only while idle, which the block does not enforce
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= USED_RESET;
        end
        else if (cfg.valid)
        begin
            used_reg <= cfg.data;
        end
    end

    // used length saturates at the map size
    always_comb
    begin
        if (32'(used_reg) > 32'(MAP_BYTES))
        begin
            lim_bytes = CNT_W'(MAP_BYTES);
        end
        else
        begin
            lim_bytes = CNT_W'(used_reg);
        end
    end

    assign req.ready   = (state_reg == S_IDLE);
    assign req_fire    = req.valid && req.ready;
    assign idx_inside  = 32'(req.data.bit_index) < 32'(MAP_BITS);
    assign len_too_big = 32'(req.data.run_length) > (32'(lim_bytes) << 3);
    assign bit_mask    = 8'(1) << bidx_reg[2:0];
    // start = bit position of the hit + 1 - run length
    assign start_full  = 32'({proc_addr_reg, scan_res.pos}) + 32'd1 - 32'(len_reg);

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        clr_op_next    = clr_op_reg;
        op_next        = op_reg;
        bidx_next      = bidx_reg;
        len_next       = len_reg;
        scan_rd_next   = scan_rd_reg;
        proc_addr_next = proc_addr_reg;
        rd_pend_next   = rd_pend_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        mem_we         = 1'b0;
        mem_wa         = '0;
        mem_wd         = '0;
        mem_re         = 1'b0;
        mem_ra         = '0;
        scan_ctl       = '0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wa = clr_addr_reg;
                if (clr_addr_reg == LAST_ADDR)
                begin
                    clr_op_next = 1'b0;
                    if (clr_op_reg)
                    begin
                        res_next   = '0;
                        state_next = S_HOLD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    clr_addr_next = ADDR_W'(clr_addr_reg + 1'b1);
                end
            end

            S_IDLE:
            begin
                if (req_fire)
                begin
                    op_next   = req.data.operation;
                    bidx_next = req.data.bit_index;
                    len_next  = req.data.run_length;
                    res_next  = '0;
                    unique case (req.data.operation) inside
                        OP_TEST, OP_SET, OP_CLEAR:
                        begin
                            if (idx_inside)
                            begin
                                mem_re     = 1'b1;
                                mem_ra     = ADDR_W'(req.data.bit_index >> 3);
                                state_next = S_BIT;
                            end
                            else
                            begin
                                state_next = S_HOLD;
                            end
                        end
                        OP_FIND:
                        begin
                            if ((req.data.run_length == '0) || len_too_big)
                            begin
                                state_next = S_HOLD;
                            end
                            else
                            begin
                                scan_rd_next = '0;
                                rd_pend_next = 1'b0;
                                scan_ctl.clr = 1'b1;
                                state_next   = S_FIND;
                            end
                        end
                        OP_CLEAR_MAP:
                        begin
                            clr_addr_next = '0;
                            clr_op_next   = 1'b1;
                            state_next    = S_CLEAR;
                        end
                        default:
                        begin
                            state_next = S_HOLD;
                        end
                    endcase
                end
            end

            S_BIT:
            begin
                res_next = '0;
                if (op_reg == OP_TEST)
                begin
                    res_next.bit_value = mem_rd[bidx_reg[2:0]];
                end
                else
                begin
                    mem_we = 1'b1;
                    mem_wa = ADDR_W'(bidx_reg >> 3);
                    mem_wd = (op_reg == OP_SET) ? (mem_rd | bit_mask) : (mem_rd & ~bit_mask);
                end
                state_next = S_HOLD;
            end

            S_FIND:
            begin
                // byte read last cycle is scanned now, next byte read overlaps
                scan_ctl.step = rd_pend_reg;
                if (rd_pend_reg && scan_res.hit)
                begin
                    res_next             = '0;
                    res_next.found       = 1'b1;
                    res_next.start_index = start_full[IDX_W-1:0];
                    rd_pend_next         = 1'b0;
                    state_next           = S_HOLD;
                end
                else if (scan_rd_reg < lim_bytes)
                begin
                    mem_re         = 1'b1;
                    mem_ra         = ADDR_W'(scan_rd_reg);
                    proc_addr_next = ADDR_W'(scan_rd_reg);
                    scan_rd_next   = CNT_W'(scan_rd_reg + 1'b1);
                    rd_pend_next   = 1'b1;
                end
                else if (!rd_pend_reg)
                begin
                    res_next   = '0;
                    state_next = S_HOLD;
                end
                else
                begin
                    rd_pend_next = 1'b0;
                end
            end

            S_HOLD:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            clr_op_reg    <= 1'b0;
            op_reg        <= '0;
            bidx_reg      <= '0;
            len_reg       <= '0;
            scan_rd_reg   <= '0;
            proc_addr_reg <= '0;
            rd_pend_reg   <= 1'b0;
            res_reg       <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            clr_op_reg    <= clr_op_next;
            op_reg        <= op_next;
            bidx_reg      <= bidx_next;
            len_reg       <= len_next;
            scan_rd_reg   <= scan_rd_next;
            proc_addr_reg <= proc_addr_next;
            rd_pend_reg   <= rd_pend_next;
            res_reg       <= res_next;
            out_reg       <= out_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    // an accepted word always leaves idle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> state_reg != S_IDLE)
        else $error("request accepted but controller stayed idle");

    // the map is never written while idle
    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !mem_we)
        else $error("map write while idle");

    // a word is only found by a find, so no tested bit rides with it
    a_found_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.data.found && rsp.data.bit_value))
        else $error("found and bit_value both set");

    // start index is zero unless a run was found
    a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.data.found) |-> rsp.data.start_index == '0)
        else $error("start_index nonzero without a found run");

    // the scanner only steps on a byte read in the previous cycle
    a_step_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        scan_ctl.step |-> $past(mem_re))
        else $error("scanner stepped without a map read");

endmodule

`default_nettype wire

[sim/bitmap_run_allocator_unit_tb.sv]
// Self-checking testbench for the bitmap run allocator: directed table, then random phases.
module bitmap_run_allocator_unit_tb;
    import bra_pkg::*;

    localparam int MAP_BITS  = MAP_BITS_DEF;
    localparam int MAP_BYTES = MAP_BITS / 8;
    localparam logic [7:0] FULL_BYTE = 8'hff;

    // Codes with no defined operation
    localparam logic [OP_W-1:0] OP_RSVD_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_LAST  = 3'd7;

    localparam int DRAIN_CYCLES  = 600;   // longer than a full-map find or clear
    localparam int STALL_AT_WORD = 300;   // rsp word after which the long hold-off starts
    localparam int STALL_CYCLES  = 400;

    typedef enum bit {ROW_REQ, ROW_CFG} row_kind_t;

    // One line of the directed table. A ROW_CFG line writes used_bytes from val.
    // Where typed is set, the expected word is the one written in the line.
    typedef struct {
        row_kind_t        kind;
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] idx;
        logic [LEN_W-1:0] len;
        bit               typed;
        bit               bv;
        bit               fnd;
        logic [IDX_W-1:0] st;
        used_t            val;
    } dir_row_t;

    logic clk;
    logic rst_n;

    bra_chan_if #(.data_t(req_t))  req_if ();
    bra_chan_if #(.data_t(rsp_t))  rsp_if ();
    bra_chan_if #(.data_t(used_t)) cfg_if ();

    bitmap_run_allocator_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    // Shadow of the allocation map and of the used-length register
    logic [MAP_BITS-1:0] shadow_map;
    used_t               shadow_used;

    rsp_t     expected_rsp_q [$];
    int       mismatch_cnt;
    bit       tx_burst;       // sender offers back to back while set
    bit       rx_burst;       // receiver never holds off while set
    int       rx_hold;        // cycles the receiver still holds ready low
    int       rx_count;       // rsp words taken so far
    dir_row_t dir_rows [$];

    // used_bytes per random phase; large maps get few items since a find walks every byte
    int phase_used [14] = '{1, 4, 16, 2, 8, 600, 32, 3, 64, 512, 12, 1023, 6, 24};

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Work out the response word for one request and move the shadow state on.
    function automatic rsp_t predict_rsp(input req_t r);
        rsp_t res;
        int   limit;
        int   run;
        int   i;
        int   len;
        res   = '0;
        limit = ((shadow_used > MAP_BYTES) ? MAP_BYTES : int'(shadow_used)) * 8;
        case (r.operation)
            OP_TEST:
            begin
                if (int'(r.bit_index) < MAP_BITS)
                    res.bit_value = shadow_map[r.bit_index];
            end
            OP_SET:
            begin
                if (int'(r.bit_index) < MAP_BITS)
                    shadow_map[r.bit_index] = 1'b1;
            end
            OP_CLEAR:
            begin
                if (int'(r.bit_index) < MAP_BITS)
                    shadow_map[r.bit_index] = 1'b0;
            end
            OP_FIND:
            begin
                len = int'(r.run_length);
                run = 0;
                i   = 0;
                // zero length, or longer than the bits in use: not found
                if (len != 0 && len <= limit)
                begin
                    while (i < limit && !res.found)
                    begin
                        // a full byte at a byte boundary with no run open is skipped whole
                        if ((i % 8) == 0 && run == 0 && shadow_map[i +: 8] == FULL_BYTE)
                            i += 8;
                        else
                        begin
                            if (!shadow_map[i])
                            begin
                                run++;
                                if (run == len)
                                begin
                                    res.found       = 1'b1;
                                    res.start_index = IDX_W'(i + 1 - len);
                                end
                            end
                            else
                                run = 0;
                            i++;
                        end
                    end
                end
            end
            OP_CLEAR_MAP:
                shadow_map = '0;
            default:
                ;   // unused codes: no change, all-zero word
        endcase
        return res;
    endfunction

    // Random request shaped for a map of used_bits bits in use.
    function automatic req_t make_req(input int used_bits);
        req_t r;
        int   pick;
        int   win;
        int   short_max;
        win  = (used_bits < 8) ? 8 : used_bits;
        pick = $urandom_range(0, 99);
        if (pick < 20)
            r.operation = OP_TEST;
        else if (pick < 50)
            r.operation = OP_SET;
        else if (pick < 65)
            r.operation = OP_CLEAR;
        else if (pick < 95)
            r.operation = OP_FIND;
        else if (pick < 97)
            r.operation = OP_CLEAR_MAP;
        else
            r.operation = OP_W'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
        // mostly inside the used window so finds see a busy map; the rest anywhere
        if ($urandom_range(0, 9) < 8)
            r.bit_index = IDX_W'($urandom_range(0, win - 1));
        else
            r.bit_index = IDX_W'($urandom_range(0, MAP_BITS - 1));
        r.run_length = LEN_W'($urandom_range(0, 8191));
        if (r.operation == OP_FIND)
        begin
            short_max = (win < 24) ? win : 24;
            case ($urandom_range(0, 19))
                0:       r.run_length = '0;
                1:       r.run_length = LEN_W'(used_bits);
                2:       r.run_length = LEN_W'(used_bits + 1);
                3:       ;   // keep the full-range length
                default: r.run_length = LEN_W'($urandom_range(1, short_max));
            endcase
        end
        return r;
    endfunction

    // Offer one request word after a random gap; queue its expected rsp word on acceptance.
    task automatic send_req(input req_t r, input bit typed, input rsp_t typed_rsp);
        int   gap;
        rsp_t pred;
        gap = tx_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            @(negedge clk);
            req_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        do @(posedge clk); while (!req_if.ready);
        pred = predict_rsp(r);
        expected_rsp_q.push_back(typed ? typed_rsp : pred);
    endtask

    // Write used_bytes once the block has gone idle.
    task automatic write_used(input used_t v);
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (expected_rsp_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= v;
        do @(posedge clk); while (!cfg_if.ready);
        shadow_used = v;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Receiver: ready drops for rx_hold cycles after each word taken
    initial
    begin
        rsp_if.ready = 1'b0;
        rx_hold      = 0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                rsp_if.ready <= 1'b0;
                rx_hold = rx_hold - 1;
            end
            else
                rsp_if.ready <= rst_n;
        end
    end

    // Compare each rsp word taken with the oldest expected word
    always @(posedge clk)
    begin : rsp_check
        rsp_t exp_w;
        if (rsp_if.valid && rsp_if.ready)
        begin
            rx_count++;
            if (expected_rsp_q.size() == 0)
            begin
                $display("%0t: rsp word with none expected, actual bit_value=%0b found=%0b start_index=%0d",
                         $time, rsp_if.data.bit_value, rsp_if.data.found,
                         rsp_if.data.start_index);
                mismatch_cnt++;
            end
            else
            begin
                exp_w = expected_rsp_q.pop_front();
                if (rsp_if.data !== exp_w)
                begin
                    $display("%0t: rsp word %0d: expected bit_value=%0b found=%0b start_index=%0d",
                             $time, rx_count, exp_w.bit_value, exp_w.found, exp_w.start_index);
                    $display("%0t: rsp word %0d: actual   bit_value=%0b found=%0b start_index=%0d",
                             $time, rx_count, rsp_if.data.bit_value, rsp_if.data.found,
                             rsp_if.data.start_index);
                    mismatch_cnt++;
                end
            end
            // one long hold-off so the block fills up and stalls req
            if (rx_count == STALL_AT_WORD)
                rx_hold = STALL_CYCLES;
            else
            begin
                if ($urandom_range(0, 29) == 0)
                    rx_burst = !rx_burst;
                rx_hold = rx_burst ? 0 : $urandom_range(0, 10);
            end
        end
    end

    initial
    begin
        req_t r;
        rsp_t t;
        int   eff;
        int   n;

        rst_n        = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        shadow_map   = '0;
        shadow_used  = USED_RESET;
        mismatch_cnt = 0;
        rx_count     = 0;
        tx_burst     = 1'b0;
        rx_burst     = 1'b0;

        //                 kind     op            idx   len   ty bv fd st  val
        // map empty, used_bytes at its reset value of 512
        dir_rows.push_back('{ROW_REQ, OP_TEST,      0,    0, 1, 0, 0, 0,    0});
        dir_rows.push_back('{ROW_REQ, OP_FIND,      0,    0, 1, 0, 0, 0,    0}); // zero run
        dir_rows.push_back('{ROW_REQ, OP_FIND,      0, 4096, 1, 0, 1, 0,    0}); // whole map
        dir_rows.push_back('{ROW_REQ, OP_FIND,   4095, 8191, 1, 0, 0, 0,    0}); // too long
        dir_rows.push_back('{ROW_REQ, OP_SET,       0,    0, 0, 0, 0, 0,    0});
        dir_rows.push_back('{ROW_REQ, OP_TEST,      0,    0, 1, 1, 0, 0,    0});
        dir_rows.push_back('{ROW_REQ, OP_SET,    4095,    0, 0, 0, 0, 0,    0});
        dir_rows.push_back('{ROW_REQ, OP_TEST,   4095,    0, 1, 1, 0, 0,    0});
        dir_rows.push_back('{ROW_REQ, OP_FIND,      0, 4094, 1, 0, 1, 1,    0});
        // fill byte 0 so the next find skips a full byte
        dir_rows.push_back('{ROW_REQ, OP_SET,       1,    0, 0, 0, 0, 0,    0});
        dir_rows.push_back('{ROW_REQ, OP_SET,       2,    0, 0, 0, 0, 0,    0});
        dir_rows.push_back('{ROW_REQ, OP_SET,       3,    0, 0, 0, 0, 0,    0});
        dir_rows.push_back('{ROW_REQ, OP_SET,       4,    0, 0, 0, 0, 0,    0});
        dir_rows.push_back('{ROW_REQ, OP_SET,       5,    0, 0, 0, 0, 0,    0});
        dir_rows.push_back('{ROW_REQ, OP_SET,       6,    0, 0, 0, 0, 0,    0});
        dir_rows.push_back('{ROW_REQ, OP_SET,       7,    0, 0, 0, 0, 0,    0});
        dir_rows.push_back('{ROW_REQ, OP_FIND,      0,    3, 1, 0, 1, 8,    0});
        dir_rows.push_back('{ROW_REQ, OP_CLEAR,     3,    0, 0, 0, 0, 0,    0});
        dir_rows.push_back('{ROW_REQ, OP_FIND,      0,    1, 1, 0, 1, 3,    0});
        // unused code: no change, all-zero word
        dir_rows.push_back('{ROW_REQ, OP_RSVD_FIRST, 4095, 8191, 1, 0, 0, 0, 0});
        dir_rows.push_back('{ROW_REQ, OP_CLEAR_MAP, 0,    0, 1, 0, 0, 0,    0});
        // nothing in use: find never hits
        dir_rows.push_back('{ROW_CFG, OP_TEST,      0,    0, 0, 0, 0, 0,    0});
        dir_rows.push_back('{ROW_REQ, OP_FIND,      0,    1, 1, 0, 0, 0,    0});
        // above the map size: saturates to the whole map
        dir_rows.push_back('{ROW_CFG, OP_TEST,      0,    0, 0, 0, 0, 0, 1023});
        dir_rows.push_back('{ROW_REQ, OP_FIND,      0, 4096, 1, 0, 1, 0,    0});
        // one byte in use: bits beyond it still set and test, find stays inside it
        dir_rows.push_back('{ROW_CFG, OP_TEST,      0,    0, 0, 0, 0, 0,    1});
        dir_rows.push_back('{ROW_REQ, OP_SET,     100,    0, 0, 0, 0, 0,    0});
        dir_rows.push_back('{ROW_REQ, OP_TEST,    100,    0, 1, 1, 0, 0,    0});
        dir_rows.push_back('{ROW_REQ, OP_FIND,      0,    9, 1, 0, 0, 0,    0});
        dir_rows.push_back('{ROW_REQ, OP_FIND,      0,    8, 1, 0, 1, 0,    0});

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table; req is held off by the block's clearing pass at first
        foreach (dir_rows[k])
        begin
            if (dir_rows[k].kind == ROW_CFG)
                write_used(dir_rows[k].val);
            else
            begin
                r.operation     = dir_rows[k].op;
                r.bit_index     = dir_rows[k].idx;
                r.run_length    = dir_rows[k].len;
                t.bit_value     = dir_rows[k].bv;
                t.found         = dir_rows[k].fnd;
                t.start_index   = dir_rows[k].st;
                send_req(r, dir_rows[k].typed, t);
            end
        end

        // random phases, one used_bytes setting each
        foreach (phase_used[p])
        begin
            write_used(USED_W'(phase_used[p]));
            eff = ((phase_used[p] > MAP_BYTES) ? MAP_BYTES : phase_used[p]) * 8;
            n   = (eff >= 2048) ? 60 : 160;
            repeat (n)
            begin
                if ($urandom_range(0, 39) == 0)
                    tx_burst = !tx_burst;
                send_req(make_req(eff), 1'b0, '0);
            end
        end

        @(negedge clk);
        req_if.valid <= 1'b0;
        while (expected_rsp_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("bitmap_run_allocator_unit: match");
        else
            $display("bitmap_run_allocator_unit: mismatch");
        $finish;
    end

    // Hard limit well beyond the slowest legal run
    initial
    begin
        #40000000;
        $display("bitmap_run_allocator_unit: mismatch");
        $finish;
    end

endmodule
